FILE: hdl/sscsp_pkg.sv
// Shared types and constants for the segmented S-curve speed planner.
// Sequencer states, phase and request kind codes, register indexes, reset table.
// No dependencies.
`default_nettype none

package sscsp_pkg;

  localparam int SEGMENTS_DEF = 6;
  localparam int SEG_MAX      = 6;

  localparam int SPD_W   = 16;
  localparam int HDG_W   = 16;
  localparam int LEN_W   = 12;
  localparam int WORD_W  = 44;
  localparam int SEG_W   = 3;
  localparam int CIDX_W  = 3;
  localparam int TDATA_W = 24;

  // serial multiply / divide
  localparam int STEP_W  = 4;
  localparam int MUL_A_W = 52;
  localparam int MUL_B_W = 36;
  localparam int MPL_A_W = 16;
  localparam int QUO_W   = 16;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_EXIT  = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_FIN_HEADING = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_FIN_RAMP    = 3'd7;

  localparam logic [2:0]       PID_HOLD_TICKS = 3'd5;
  localparam logic [SPD_W-1:0] STOP_BELOW     = 16'd384;

  localparam logic [HDG_W-1:0] FIN_HEADING_RST = 16'd20480;
  localparam logic [LEN_W-1:0] FIN_RAMP_RST    = 12'd250;

  localparam logic [WORD_W-1:0] SEG_RST [SEG_MAX] = '{
    44'd645335613440,
    44'd1090522240,
    44'd516201388288,
    44'd805315968,
    44'd516486608000,
    44'd1090536960
  };

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_FINISH,
    PH_STOP
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_ECHK,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_DIV,
    S_EEND,
    S_SEGSET,
    S_STEP,
    S_APPLY,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/segmented_scurve_speed_planner.sv
// Segmented S-curve speed planner, top level; depends on sscsp_pkg.
// From accept to out_tvalid: start, exit and idle ticks go through decode and emit only; a running
// tick makes one smoothstep evaluation, or two with a segment change, each three 16-step shift-add
// multiplies and a 16-step divide, skipped once the ramp has ended.
// One request at a time, the next taken the cycle after the result is loaded.
// Reset (rst_n, synchronous): idle, segment 0, registers at their default values.
`default_nettype none

module segmented_scurve_speed_planner #(
  parameter int SEGMENTS = sscsp_pkg::SEGMENTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // in_tdata: [15:0] heading, [16] finish_seen, rest zero
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [sscsp_pkg::TDATA_W-1:0]      in_tdata,
  // in_tuser: [1:0] kind
  input  wire  [1:0]                         in_tuser,
  // out_tdata: [15:0] speed_command, [17:16] run_phase, [20:18] segment_number,
  //            [21] pid_enable, rest zero
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [sscsp_pkg::TDATA_W-1:0]      out_tdata,
  output logic                               out_tlast,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [sscsp_pkg::CIDX_W-1:0]       cfg_index,
  input  wire  [sscsp_pkg::WORD_W-1:0]       cfg_data
);

  import sscsp_pkg::*;

  localparam int SegIdxW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam logic [SEG_W-1:0] SegCnt = SEG_W'(SEGMENTS);
  localparam logic [STEP_W-1:0] StepLast = '1;

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [WORD_W-1:0]       seg_word_r [SEGMENTS];
  logic signed [HDG_W-1:0] fin_heading_r;
  logic [LEN_W-1:0]        fin_ramp_r;

  logic [SEG_W-1:0] seg_now_r;
  logic [SPD_W-1:0] ramp_from_r;
  logic [SPD_W-1:0] ramp_to_r;
  logic [LEN_W-1:0] ramp_len_r;
  logic [LEN_W-1:0] ramp_cnt_r;
  logic [2:0]       hold_r;

  logic [1:0]              kind_r;
  logic signed [HDG_W-1:0] hd_r;
  logic                    fin_r;

  logic [SEG_W-1:0] srch_i_r;
  logic [SEG_W-1:0] ni_r;
  logic             adv_r;

  logic [STEP_W-1:0]  step_r;
  logic [MUL_A_W-1:0] mc_a_r;
  logic [MUL_A_W-1:0] acc_a_r;
  logic [MPL_A_W-1:0] mpl_a_r;
  logic [MUL_B_W-1:0] mc_b_r;
  logic [MUL_B_W-1:0] acc_b_r;
  logic [LEN_W-1:0]   mpl_b_r;
  logic [MUL_B_W-1:0] rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic               neg_r;
  logic [SPD_W-1:0]   val_r;

  logic [SPD_W-1:0] res_spd_r;
  logic             res_pid_r;
  logic             res_stp_r;

  logic               out_tvalid_r;
  logic [TDATA_W-1:0] out_tdata_r;
  logic               out_tlast_r;

  logic [SegIdxW-1:0]      rd_sel;
  logic [WORD_W-1:0]       rd_word;
  logic signed [HDG_W-1:0] rd_thr;
  logic                    srch_hit;
  logic                    eval_short;
  logic                    step_last;
  logic                    out_free;
  logic [MUL_A_W-1:0]      acc_a_add;
  logic [MUL_B_W-1:0]      acc_b_add;
  logic [SPD_W:0]          diff;
  logic [SPD_W:0]          diff_abs;
  logic [LEN_W+1:0]        shape;
  logic [MUL_B_W:0]        div_t;
  logic [MUL_B_W:0]        div_d;
  logic                    div_ge;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign rd_word    = seg_word_r[rd_sel];
  assign rd_thr     = $signed(rd_word[15:0]);
  assign srch_hit   = (srch_i_r < SegCnt) && (hd_r >= rd_thr);
  assign eval_short = (ramp_len_r == '0) || (ramp_cnt_r >= ramp_len_r);
  assign step_last  = (step_r == StepLast);
  assign out_free   = !out_tvalid_r || out_tready;

  assign acc_a_add = acc_a_r + (mpl_a_r[0] ? mc_a_r : '0);
  assign acc_b_add = acc_b_r + (mpl_b_r[0] ? mc_b_r : '0);

  assign diff     = {1'b0, ramp_to_r} - {1'b0, ramp_from_r};
  assign diff_abs = diff[SPD_W] ? ((SPD_W+1)'(0) - diff) : diff;
  // 3d - 2c, positive while c < d
  assign shape    = {2'b00, ramp_len_r} + {1'b0, ramp_len_r, 1'b0}
                    - {1'b0, ramp_cnt_r, 1'b0};

  assign div_t  = {rem_r, quo_r[QUO_W-1]};
  assign div_d  = div_t - {1'b0, acc_b_r};
  assign div_ge = (div_t >= {1'b0, acc_b_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (kind_r == KIND_TICK && phase_r == PH_RUN) begin
          state_nxt = S_SEARCH;
        end else if (kind_r == KIND_TICK && phase_r == PH_FINISH) begin
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SEARCH: begin
        if (!srch_hit) state_nxt = (ni_r != seg_now_r) ? S_ECHK : S_STEP;
      end
      S_ECHK: begin
        if (eval_short) state_nxt = adv_r ? S_APPLY : S_SEGSET;
        else            state_nxt = S_MUL1;
      end
      S_MUL1:   if (step_last) state_nxt = S_MUL2;
      S_MUL2:   if (step_last) state_nxt = S_MUL3;
      S_MUL3:   if (step_last) state_nxt = S_DIV;
      S_DIV:    if (step_last) state_nxt = S_EEND;
      S_EEND:   state_nxt = adv_r ? S_APPLY : S_SEGSET;
      S_SEGSET: state_nxt = S_STEP;
      S_STEP:   state_nxt = S_ECHK;
      S_APPLY:  state_nxt = S_EMIT;
      S_EMIT:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    rd_sel    = ni_r[SegIdxW-1:0];
    case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_DECODE: rd_sel = '0;
      S_SEARCH: rd_sel = srch_i_r[SegIdxW-1:0];
      default:  rd_sel = ni_r[SegIdxW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_IDLE;
      seg_now_r     <= '0;
      ramp_from_r   <= '0;
      ramp_to_r     <= SEG_RST[0][31:16];
      ramp_len_r    <= SEG_RST[0][43:32];
      ramp_cnt_r    <= '0;
      hold_r        <= '0;
      fin_heading_r <= $signed(FIN_HEADING_RST);
      fin_ramp_r    <= FIN_RAMP_RST;
      out_tvalid_r  <= 1'b0;
      for (int k = 0; k < SEGMENTS; k++) seg_word_r[k] <= SEG_RST[k];
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        if (cfg_index < CIDX_W'(SEGMENTS)) begin
          seg_word_r[cfg_index[SegIdxW-1:0]] <= cfg_data;
        end else if (cfg_index == CFG_FIN_HEADING) begin
          fin_heading_r <= $signed(cfg_data[HDG_W-1:0]);
        end else if (cfg_index == CFG_FIN_RAMP) begin
          fin_ramp_r <= cfg_data[LEN_W-1:0];
        end
      end

      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r    <= in_tuser;
            hd_r      <= $signed(in_tdata[HDG_W-1:0]);
            fin_r     <= in_tdata[HDG_W];
            res_spd_r <= '0;
            res_pid_r <= 1'b0;
            res_stp_r <= 1'b0;
          end
        end
        S_DECODE: begin
          case (kind_r)
            KIND_START: begin
              phase_r     <= PH_RUN;
              seg_now_r   <= '0;
              ramp_from_r <= '0;
              ramp_to_r   <= rd_word[31:16];
              ramp_len_r  <= rd_word[43:32];
              ramp_cnt_r  <= '0;
            end
            KIND_EXIT: begin
              phase_r   <= PH_IDLE;
              res_stp_r <= 1'b1;
            end
            KIND_TICK: begin
              srch_i_r <= seg_now_r + SEG_W'(1);
              ni_r     <= seg_now_r;
            end
            default: ;
          endcase
        end
        S_SEARCH: begin
          if (srch_hit) begin
            ni_r     <= srch_i_r;
            srch_i_r <= srch_i_r + SEG_W'(1);
          end else begin
            adv_r <= 1'b0;
          end
        end
        S_ECHK: begin
          step_r  <= '0;
          neg_r   <= diff[SPD_W];
          mc_a_r  <= MUL_A_W'(ramp_cnt_r);
          mpl_a_r <= MPL_A_W'(ramp_cnt_r);
          acc_a_r <= '0;
          mc_b_r  <= MUL_B_W'(ramp_len_r);
          mpl_b_r <= ramp_len_r;
          acc_b_r <= '0;
          if (eval_short) val_r <= ramp_to_r;
        end
        S_MUL1, S_MUL2: begin
          step_r  <= step_r + STEP_W'(1);
          mc_a_r  <= {mc_a_r[MUL_A_W-2:0], 1'b0};
          mpl_a_r <= {1'b0, mpl_a_r[MPL_A_W-1:1]};
          acc_a_r <= acc_a_add;
          mc_b_r  <= {mc_b_r[MUL_B_W-2:0], 1'b0};
          mpl_b_r <= {1'b0, mpl_b_r[LEN_W-1:1]};
          acc_b_r <= acc_b_add;
          if (step_last) begin
            acc_a_r <= '0;
            mc_a_r  <= acc_a_add;
            if (state_r == S_MUL1) begin
              // c^2 * (3d - 2c) and d^2 * d
              mpl_a_r <= MPL_A_W'(shape);
              acc_b_r <= '0;
              mc_b_r  <= acc_b_add;
              mpl_b_r <= ramp_len_r;
            end else begin
              // numerator times |to - from|; den stays in acc_b_r
              mpl_a_r <= diff_abs[SPD_W-1:0];
            end
          end
        end
        S_MUL3: begin
          step_r  <= step_r + STEP_W'(1);
          mc_a_r  <= {mc_a_r[MUL_A_W-2:0], 1'b0};
          mpl_a_r <= {1'b0, mpl_a_r[MPL_A_W-1:1]};
          acc_a_r <= acc_a_add;
          if (step_last) begin
            rem_r <= acc_a_add[MUL_A_W-1:QUO_W];
            quo_r <= acc_a_add[QUO_W-1:0];
          end
        end
        S_DIV: begin
          step_r <= step_r + STEP_W'(1);
          rem_r  <= div_ge ? div_d[MUL_B_W-1:0] : div_t[MUL_B_W-1:0];
          quo_r  <= {quo_r[QUO_W-2:0], div_ge};
        end
        S_EEND: begin
          val_r <= neg_r ? (ramp_from_r - quo_r) : (ramp_from_r + quo_r);
        end
        S_SEGSET: begin
          ramp_from_r <= val_r;
          ramp_to_r   <= rd_word[31:16];
          ramp_len_r  <= rd_word[43:32];
          ramp_cnt_r  <= '0;
          seg_now_r   <= ni_r;
        end
        S_STEP: begin
          adv_r <= 1'b1;
          if (ramp_len_r != '0 && ramp_cnt_r < ramp_len_r) begin
            ramp_cnt_r <= ramp_cnt_r + LEN_W'(1);
          end
        end
        S_APPLY: begin
          res_spd_r <= val_r;
          res_pid_r <= (hold_r == '0);
          if (hold_r != '0) hold_r <= hold_r - 3'd1;
          if (phase_r == PH_RUN) begin
            if (hd_r > fin_heading_r && fin_r) begin
              phase_r     <= PH_FINISH;
              hold_r      <= PID_HOLD_TICKS;
              ramp_from_r <= val_r;
              ramp_to_r   <= '0;
              ramp_len_r  <= fin_ramp_r;
              ramp_cnt_r  <= '0;
            end
          end else if (val_r < STOP_BELOW) begin
            phase_r   <= PH_STOP;
            res_spd_r <= '0;
            res_stp_r <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {2'b00, res_pid_r, seg_now_r, phase_r, res_spd_r};
            out_tlast_r  <= res_stp_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: dv/segmented_scurve_speed_planner_tb.sv
// Self-checking bench for segmented_scurve_speed_planner: start, exit and tick
// requests with random stalls on both streams, checked against a cycle-free plan model.
// Depends on sscsp_pkg and the planner RTL only.
`timescale 1ns / 100ps

module segmented_scurve_speed_planner_tb;
  import sscsp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LAP_ITEMS = 235;

  typedef struct {
    logic [SPD_W-1:0] speed;
    phase_t           phase;
    logic [SEG_W-1:0] seg;
    logic             pid;
    logic             stop;
  } speed_cmd_t;

  class speed_plan_board;
    logic [WORD_W-1:0] seg_word [SEG_MAX];
    logic [HDG_W-1:0]  fin_hdg;
    logic [LEN_W-1:0]  fin_ramp;
    phase_t            phase;
    logic [SEG_W-1:0]  seg_now;
    logic [SPD_W-1:0]  ramp_from;
    logic [SPD_W-1:0]  ramp_to;
    logic [LEN_W-1:0]  ramp_len;
    logic [LEN_W-1:0]  ramp_cnt;
    logic [2:0]        hold;
    speed_cmd_t        planned_cmds [$];
    int                mismatches;

    function new();
      for (int i = 0; i < SEG_MAX; i++) seg_word[i] = SEG_RST[i];
      fin_hdg    = FIN_HEADING_RST;
      fin_ramp   = FIN_RAMP_RST;
      phase      = PH_IDLE;
      seg_now    = '0;
      hold       = '0;
      mismatches = 0;
      begin_ramp('0, seg_word[0][31:16], seg_word[0][43:32]);
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [WORD_W-1:0] val);
      if (idx < CFG_FIN_HEADING) seg_word[idx] = val;
      else if (idx == CFG_FIN_HEADING) fin_hdg = val[HDG_W-1:0];
      else fin_ramp = val[LEN_W-1:0];
    endfunction

    function void begin_ramp(logic [SPD_W-1:0] from, logic [SPD_W-1:0] to,
                             logic [LEN_W-1:0] len);
      ramp_from = from;
      ramp_to   = to;
      ramp_len  = len;
      ramp_cnt  = '0;
    endfunction

    // smoothstep, delta truncated toward zero
    function logic [SPD_W-1:0] ramp_now();
      longint d, c, num, den, delta;
      if (ramp_len == 0 || ramp_cnt >= ramp_len) return ramp_to;
      d     = ramp_len;
      c     = ramp_cnt;
      num   = c * c * (3 * d - 2 * c);
      den   = d * d * d;
      delta = (longint'(ramp_to) - longint'(ramp_from)) * num / den;
      return SPD_W'(longint'(ramp_from) + delta);
    endfunction

    function logic [SPD_W-1:0] ramp_step();
      if (ramp_len == 0) return ramp_to;
      if (ramp_cnt < ramp_len) ramp_cnt++;
      return ramp_now();
    endfunction

    function logic [SEG_W-1:0] next_segment(logic [HDG_W-1:0] hd);
      logic [SEG_W-1:0] idx;
      idx = seg_now;
      for (int i = seg_now + 1; i < SEGMENTS_DEF; i++) begin
        if ($signed(hd) >= $signed(seg_word[i][15:0])) idx = SEG_W'(i);
        else break;
      end
      return idx;
    endfunction

    function logic pid_gate();
      if (hold == 0) return 1'b1;
      hold--;
      return 1'b0;
    endfunction

    function int pending();
      return planned_cmds.size();
    endfunction

    function void take_request(logic [1:0] kind, logic [HDG_W-1:0] hd, logic fin);
      speed_cmd_t       r;
      logic [SEG_W-1:0] nxt;
      logic [SPD_W-1:0] cur;
      r.speed = '0;
      r.pid   = 1'b0;
      r.stop  = 1'b0;
      case (kind)
        KIND_START: begin
          phase   = PH_RUN;
          seg_now = '0;
          begin_ramp('0, seg_word[0][31:16], seg_word[0][43:32]);
        end
        KIND_EXIT: begin
          phase  = PH_IDLE;
          r.stop = 1'b1;
        end
        KIND_TICK: begin
          if (phase == PH_RUN) begin
            nxt = next_segment(hd);
            if (nxt != seg_now) begin
              cur = ramp_now();
              begin_ramp(cur, seg_word[nxt][31:16], seg_word[nxt][43:32]);
              seg_now = nxt;
            end
            r.speed = ramp_step();
            r.pid   = pid_gate();
            if ($signed(hd) > $signed(fin_hdg) && fin) begin
              cur   = ramp_now();
              phase = PH_FINISH;
              hold  = PID_HOLD_TICKS;
              begin_ramp(cur, '0, fin_ramp);
            end
          end else if (phase == PH_FINISH) begin
            r.speed = ramp_step();
            r.pid   = pid_gate();
            if (r.speed < STOP_BELOW) begin
              phase   = PH_STOP;
              r.speed = '0;
              r.stop  = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.phase = phase;
      r.seg   = seg_now;
      planned_cmds.push_back(r);
    endfunction

    task flag_mismatch(string field, longint got, longint want);
      if (mismatches < 50)
        $display("%0t: %s wrong, got %0d, wanted %0d", $realtime, field, got, want);
      mismatches++;
    endtask

    task check_command(logic [TDATA_W-1:0] td, logic last);
      speed_cmd_t e;
      if (planned_cmds.size() == 0) begin
        flag_mismatch("unrequested result", td, 0);
        return;
      end
      e = planned_cmds.pop_front();
      if (td[15:0] !== e.speed) flag_mismatch("speed_command", td[15:0], e.speed);
      if (td[17:16] !== e.phase) flag_mismatch("run_phase", td[17:16], e.phase);
      if (td[20:18] !== e.seg) flag_mismatch("segment_number", td[20:18], e.seg);
      if (td[21] !== e.pid) flag_mismatch("pid_enable", td[21], e.pid);
      if (td[23:22] !== 2'b00) flag_mismatch("tdata padding", td[23:22], 0);
      if (last !== e.stop) flag_mismatch("stop_event", last, e.stop);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata = '0;
  logic [1:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CIDX_W-1:0]    cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  speed_plan_board plan_sb = new();
  int tx_idle_pct = 36;
  int rx_idle_pct = 78;
  int cycle_count = 0;
  int lap_items;

  segmented_scurve_speed_planner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) plan_sb.check_command(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  task automatic send_request(input logic [1:0] kind, input logic [HDG_W-1:0] hd,
                              input logic fin);
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(19, 0) == 0) repeat ($urandom_range(160, 1)) @(posedge clk);
      do @(posedge clk); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, fin, hd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    plan_sb.take_request(kind, hd, fin);
    if (kind != KIND_UNUSED) lap_items++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (plan_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    plan_sb.set_reg(idx, val);
  endtask

  function automatic int clamp_hdg(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // thresholds mostly rising so laps walk through the segments
  task automatic program_random_plan();
    int               t;
    int               fh;
    logic [WORD_W-1:0] w;
    t = int'($urandom_range(40000, 0)) - 32768;
    for (int i = 0; i < SEG_MAX; i++) begin
      w[15:0]  = ($urandom_range(4, 0) == 0) ? 16'($urandom) : 16'(t);
      w[31:16] = 16'($urandom);
      w[43:32] = ($urandom_range(7, 0) == 0) ? 12'($urandom) : 12'($urandom_range(12, 0));
      write_reg(CIDX_W'(i), w);
      t = clamp_hdg(t + int'($urandom_range(3000, 0)));
    end
    fh = clamp_hdg(int'($signed(plan_sb.seg_word[$urandom_range(5, 0)][15:0]))
                   + int'($urandom_range(2000, 0)) - 1000);
    write_reg(CFG_FIN_HEADING, {28'($urandom), 16'(fh)});
    w = {32'($urandom), 12'($urandom_range(24, 0))};
    if ($urandom_range(9, 0) == 0) w[11:0] = 12'($urandom);
    write_reg(CFG_FIN_RAMP, w);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_lap();
    int   h, span_end, step_max, ticks, r;
    logic fin;
    send_request(KIND_START, 16'($urandom), 1'($urandom));
    h = clamp_hdg(int'($signed(plan_sb.seg_word[0][15:0])) - int'($urandom_range(500, 0)));
    span_end = int'($signed(plan_sb.seg_word[SEG_MAX-1][15:0]));
    if (int'($signed(plan_sb.fin_hdg)) > span_end) span_end = int'($signed(plan_sb.fin_hdg));
    step_max = (span_end + 200 - h) / 8 + 1;
    if (step_max < 1) step_max = 1;
    ticks = 0;
    while (ticks < 80 && plan_sb.phase != PH_STOP && plan_sb.phase != PH_IDLE) begin
      if ($urandom_range(49, 0) == 0) wait_drained();
      r = $urandom_range(99, 0);
      if (r < 3) send_request(KIND_EXIT, 16'($urandom), 1'($urandom));
      else if (r < 5) send_request(KIND_UNUSED, 16'($urandom), 1'($urandom));
      else if (r < 7) send_request(KIND_START, 16'($urandom), 1'($urandom));
      else if (r < 12) send_request(KIND_TICK, 16'($urandom), 1'($urandom));
      else begin
        h = clamp_hdg(h + int'($urandom_range(step_max, 0)));
        if (h > int'($signed(plan_sb.fin_hdg))) fin = ($urandom_range(3, 0) != 0);
        else fin = ($urandom_range(9, 0) == 0);
        send_request(KIND_TICK, 16'(h), fin);
      end
      ticks++;
    end
    repeat ($urandom_range(2, 0)) send_request(KIND_TICK, 16'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset table: idle handling, segment walk, finish and PID hold
    send_request(KIND_TICK, 16'd0, 1'b0);
    send_request(KIND_UNUSED, 16'd0, 1'b0);
    send_request(KIND_EXIT, 16'd0, 1'b0);
    send_request(KIND_START, 16'd0, 1'b0);
    send_request(KIND_TICK, 16'h8000, 1'b1);
    send_request(KIND_TICK, 16'd3200, 1'b0);
    send_request(KIND_TICK, 16'h7FFF, 1'b0);
    send_request(KIND_TICK, 16'h7FFF, 1'b1);
    send_request(KIND_UNUSED, 16'hFFFF, 1'b1);
    send_request(KIND_TICK, 16'd0, 1'b0);
    send_request(KIND_TICK, 16'd0, 1'b0);
    send_request(KIND_START, 16'd0, 1'b0);
    send_request(KIND_TICK, 16'h7FFF, 1'b0);
    send_request(KIND_EXIT, 16'd0, 1'b0);
    send_request(KIND_TICK, 16'h7FFF, 1'b1);
    wait_drained();

    // extreme words; upper bits of the short registers set to check masking
    write_reg(3'd0, {12'd0, 16'hFFFF, 16'h0000});
    write_reg(3'd1, {12'd4095, 16'h0000, 16'h8000});
    write_reg(3'd2, {12'd1, 16'hFFFF, 16'h7FFF});
    write_reg(3'd3, 44'hFFF_FFFF_FFFF);
    write_reg(3'd4, 44'h0);
    write_reg(3'd5, {12'd2, 16'h0180, 16'h7FFF});
    write_reg(CFG_FIN_HEADING, {28'hFFF_FFFF, 16'h8000});
    write_reg(CFG_FIN_RAMP, {32'hFFFF_FFFF, 12'd0});
    cfg_valid <= 1'b0;
    @(posedge clk);

    send_request(KIND_START, 16'd0, 1'b0);
    send_request(KIND_TICK, 16'h8000, 1'b0);
    send_request(KIND_TICK, 16'h7FFF, 1'b1);
    send_request(KIND_TICK, 16'd0, 1'b0);
    send_request(KIND_TICK, 16'd0, 1'b1);
    send_request(KIND_UNUSED, 16'd0, 1'b0);
    send_request(KIND_START, 16'd0, 1'b0);
    send_request(KIND_TICK, 16'd0, 1'b1);
    send_request(KIND_EXIT, 16'd0, 1'b0);

    for (int round = 0; round < 3; round++) begin
      tx_idle_pct = (round == 0) ? 36 : (round == 1) ? 78 : 0;
      rx_idle_pct = (round == 0) ? 78 : (round == 1) ? 36 : 0;
      lap_items = 0;
      for (int lap = 0; lap_items < LAP_ITEMS; lap++) begin
        if (lap % 3 == 0) begin
          wait_drained();
          program_random_plan();
        end
        run_lap();
      end
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (plan_sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
